>>> hw/rtl/rtcn_pkg.sv
package rtcn_pkg;

  localparam int unsigned BinModeBit = 2;
  localparam int unsigned H24ModeBit = 1;
  localparam int unsigned PmBit      = 7;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCentury = 2'd0,
    CfgPivot   = 2'd1,
    CfgZone    = 2'd2
  } rtcn_cfg_idx_e;

  localparam logic        CenturyReset = 1'b0;
  localparam logic [13:0] PivotReset   = 14'd2024;
  localparam logic [7:0]  PivotCentRst = 8'd20;
  localparam logic [4:0]  ZoneReset    = 5'd7;

  typedef struct packed {
    logic [7:0] raw_second;
    logic [7:0] raw_minute;
    logic [7:0] raw_hour;
    logic [7:0] raw_day;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
    logic [7:0] raw_century;
    logic [7:0] status_b;
  } rtcn_in_t;

  typedef struct packed {
    logic [5:0]  second_out;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
  } rtcn_out_t;

  // The pivot's century count is kept next to the pivot year itself.
  typedef struct packed {
    logic        century_present;
    logic [13:0] pivot_year;
    logic [7:0]  pivot_cent;
    logic [4:0]  zone_offset_hours;
  } rtcn_cfg_t;

  function automatic logic [7:0] bcd_decode(logic [7:0] b);
    return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
  endfunction

endpackage

>>> hw/rtl/rtcn_cfg.sv
module rtcn_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rtcn_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rtcn_pkg::CfgDataW-1:0]    cfg_data_i,
  output rtcn_pkg::rtcn_cfg_t              cfg_o
);
  import rtcn_pkg::*;

  rtcn_cfg_t   cfg_d, cfg_q;
  logic [26:0] pivot_prod;

  // Division by 100 as a reciprocal multiply, exact for all 14-bit pivots.
  assign pivot_prod = 27'(cfg_data_i) * 27'd5243;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCentury: cfg_d.century_present = cfg_data_i[0];
        CfgPivot: begin
          cfg_d.pivot_year = cfg_data_i;
          cfg_d.pivot_cent = pivot_prod[26:19];
        end
        CfgZone: cfg_d.zone_offset_hours = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.century_present   <= CenturyReset;
      cfg_q.pivot_year        <= PivotReset;
      cfg_q.pivot_cent        <= PivotCentRst;
      cfg_q.zone_offset_hours <= ZoneReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/rtcn_convert.sv
module rtcn_convert (
  input  rtcn_pkg::rtcn_in_t  snap_i,
  input  rtcn_pkg::rtcn_cfg_t cfg_i,
  output rtcn_pkg::rtcn_out_t result_o
);
  import rtcn_pkg::*;

  logic [7:0]  sec, min, hr, day, mon, yr, cen;
  logic [6:0]  hsum, hr7;
  logic [14:0] year, base;
  logic [7:0]  cent;
  logic [1:0]  yq;
  logic [7:0]  yrem;
  logic        leap, roll;
  logic [8:0]  hr9, day9, mon9;

  always_comb begin
    hsum = 7'(snap_i.raw_hour[3:0]) + 7'(snap_i.raw_hour[6:4]) * 7'd10;
    if (!snap_i.status_b[BinModeBit]) begin
      sec = bcd_decode(snap_i.raw_second);
      min = bcd_decode(snap_i.raw_minute);
      hr  = {snap_i.raw_hour[PmBit], hsum};
      day = bcd_decode(snap_i.raw_day);
      mon = bcd_decode(snap_i.raw_month);
      yr  = bcd_decode(snap_i.raw_year);
      cen = bcd_decode(snap_i.raw_century);
    end else begin
      sec = snap_i.raw_second;
      min = snap_i.raw_minute;
      hr  = snap_i.raw_hour;
      day = snap_i.raw_day;
      mon = snap_i.raw_month;
      yr  = snap_i.raw_year;
      cen = snap_i.raw_century;
    end

    hr7 = hr[6:0];
    if (!snap_i.status_b[H24ModeBit]) begin
      if (hr7 == 7'd12) begin
        hr7 = 7'd0;
      end
      hr = {1'b0, hr7} + (hr[PmBit] ? 8'd12 : 8'd0);
    end

    base = 15'(cfg_i.pivot_cent) * 15'd100 + 15'(yr);
    if (cfg_i.century_present) begin
      year = 15'(cen) * 15'd100 + 15'(yr);
      cent = cen;
    end else if (base < 15'(cfg_i.pivot_year)) begin
      year = base + 15'd100;
      cent = 8'(cfg_i.pivot_cent) + 8'd1;
    end else begin
      year = base;
      cent = 8'(cfg_i.pivot_cent);
    end

    // The century part is a multiple of 100, so the leap test only needs the
    // two-digit byte split into hundreds and remainder plus the century count.
    if (yr >= 8'd200) begin
      yq   = 2'd2;
      yrem = yr - 8'd200;
    end else if (yr >= 8'd100) begin
      yq   = 2'd1;
      yrem = yr - 8'd100;
    end else begin
      yq   = 2'd0;
      yrem = yr;
    end
    leap = ((yr[1:0] == 2'd0) && (yrem != 8'd0)) ||
           ((yrem == 8'd0) && ((cent[1:0] + yq) == 2'd0));

    hr9  = {1'b0, hr} + 9'(cfg_i.zone_offset_hours);
    day9 = {1'b0, day};
    mon9 = {1'b0, mon};
    roll = 1'b0;
    if (hr9 >= 9'd24) begin
      hr9  = hr9 - 9'd24;
      day9 = day9 + 9'd1;
      case (mon) inside
        8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: roll = day9 > 9'd31;
        8'd4, 8'd6, 8'd9, 8'd11:                    roll = day9 > 9'd30;
        8'd2:    roll = day9 > (leap ? 9'd29 : 9'd28);
        default: roll = 1'b0;
      endcase
      if (roll) begin
        day9 = 9'd1;
        mon9 = mon9 + 9'd1;
      end
      if (mon9 > 9'd12) begin
        mon9 = 9'd1;
        year = year + 15'd1;
      end
    end

    result_o.second_out = sec[5:0];
    result_o.minute_out = min[5:0];
    result_o.hour_out   = hr9[4:0];
    result_o.day_out    = day9[4:0];
    result_o.month_out  = mon9[3:0];
    result_o.year_out   = year[13:0];
  end

endmodule

>>> hw/rtl/rtc_time_normalizer_top.sv
// An accepted snapshot passes the input and result registers; done rises with the result.
// Throughput: one snapshot per cycle; busy is never raised.
// The receiver cannot stall; the result port holds each result until the next one.
// Reset clears the pipeline valid flags and loads the register defaults:
// no century byte, pivot year 2024, zone offset 7 hours.
module rtc_time_normalizer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rtcn_pkg::rtcn_in_t            in_i,
  output logic                          done_o,
  output rtcn_pkg::rtcn_out_t           result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rtcn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtcn_pkg::CfgDataW-1:0] cfg_data_i
);
  import rtcn_pkg::*;

  rtcn_cfg_t cfg;
  rtcn_in_t  in_q;
  logic      in_valid_q, done_q;
  rtcn_out_t res_d, res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  rtcn_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rtcn_convert u_convert (
    .snap_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= in_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> hw/rtl/rtcn_checker.sv
module rtcn_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input rtcn_pkg::rtcn_in_t  in_i,
  input logic                done_o,
  input rtcn_pkg::rtcn_out_t result_o
);
  import rtcn_pkg::*;

  // Every accepted transfer produces a result once it has passed the input and result registers.
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted snapshot produced no result");

  // No result appears without an accepted transfer that passed the input and result registers before it.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching snapshot");

  // In binary mode the low six bits of the seconds byte pass straight through.
  a_binary_seconds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(in_i.status_b[BinModeBit], 2)) |->
      (result_o.second_out == $past(in_i.raw_second[5:0], 2)))
    else $error("binary seconds not carried through");

endmodule

bind rtc_time_normalizer_top rtcn_checker u_rtcn_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .in_i     (in_i),
  .done_o   (done_o),
  .result_o (result_o)
);
